// ===== hdl/pdd_pkg.sv =====
// Shared types and constants for the power drop detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package pdd_pkg;

	localparam int unsigned SampleW   = 16;
	localparam int unsigned DebW      = 8;
	localparam int unsigned HoldW     = 16;
	localparam int unsigned CfgIndexW = 8;
	localparam int unsigned CfgDataW  = 16;

	// Register indexes of the configuration port.
	localparam logic [CfgIndexW-1:0] REG_THRESHOLD = 8'd0;
	localparam logic [CfgIndexW-1:0] REG_DEBOUNCE  = 8'd1;
	localparam logic [CfgIndexW-1:0] REG_HOLDOFF   = 8'd2;

	// Reset values of the configuration registers.
	localparam logic [SampleW-1:0] THRESHOLD_RST = 16'd70;
	localparam logic [DebW-1:0]    DEBOUNCE_RST  = 8'd10;
	localparam logic [HoldW-1:0]   HOLDOFF_RST   = 16'd600;

	// Phase codes as seen on the result port.
	localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
	localparam logic [1:0] PHASE_CODE_UP   = 2'd1;
	localparam logic [1:0] PHASE_CODE_LOST = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_UP   = 3'b010,
		PH_LOST = 3'b100
	} phase_t;

	typedef struct packed {
		logic [SampleW-1:0] threshold;
		logic [DebW-1:0]    debounce;
		logic [HoldW-1:0]   holdoff;
	} cfg_t;

	typedef struct packed {
		logic       power_good;
		logic [1:0] phase;
		logic       drop_event;
		logic       save_request;
		logic       down_flag;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/pdd_cfg.sv =====
// Configuration register file of the power drop detector.
// Depends on pdd_pkg for the register indexes and the cfg_t bundle.
`default_nettype none
module pdd_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [pdd_pkg::CfgIndexW-1:0] wr_index,
	input  wire logic [pdd_pkg::CfgDataW-1:0]  wr_data,
	output pdd_pkg::cfg_t                     cfg
);
	import pdd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RST;
			cfg_q.debounce  <= DEBOUNCE_RST;
			cfg_q.holdoff   <= HOLDOFF_RST;
		end else if (wr_en) begin
			// Writes to an index past the last register are dropped.
			if (wr_index == REG_THRESHOLD) begin
				cfg_q.threshold <= wr_data[SampleW-1:0];
			end
			if (wr_index == REG_DEBOUNCE) begin
				cfg_q.debounce <= wr_data[DebW-1:0];
			end
			if (wr_index == REG_HOLDOFF) begin
				cfg_q.holdoff <= wr_data[HoldW-1:0];
			end
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/pdd_debounce.sv =====
// Run counters and debounced power level of the power drop detector.
// Depends on pdd_pkg for widths.
`default_nettype none
module pdd_debounce (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [pdd_pkg::SampleW-1:0] sample,
	input  wire logic [pdd_pkg::SampleW-1:0] threshold,
	input  wire logic [pdd_pkg::DebW-1:0]    debounce,
	output logic                             level_next
);
	import pdd_pkg::*;

	logic [DebW-1:0] on_q;
	logic [DebW-1:0] off_q;
	logic            level_q;

	logic            present;
	logic [DebW:0]   run_inc;
	logic            passed;
	logic [DebW-1:0] run_next;

	// Only the counter of the current run advances; the other one is cleared.
	// The increment is one bit wider so a full counter still saturates.
	always_comb begin
		present  = (sample >= threshold);
		run_inc  = {1'b0, (present ? on_q : off_q)} + {{DebW{1'b0}}, 1'b1};
		passed   = (run_inc > {1'b0, debounce});
		run_next = passed ? debounce : run_inc[DebW-1:0];
		if (passed) begin
			level_next = present;
		end else begin
			level_next = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q    <= '0;
			off_q   <= '0;
			level_q <= 1'b0;
		end else if (step) begin
			on_q    <= present ? run_next : '0;
			off_q   <= present ? '0 : run_next;
			level_q <= level_next;
		end
	end

	// At most one run can be in progress at a time.
	a_one_run: assert property (@(posedge clk) disable iff (!arst_n)
		!((on_q != '0) && (off_q != '0)))
		else $error("both run counters are nonzero");

endmodule
`default_nettype wire

// ===== hdl/pdd_phase.sv =====
// Save holdoff timer and idle/up/lost phase machine of the power drop detector.
// Depends on pdd_pkg for phase_t and result_t.
`default_nettype none
module pdd_phase (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      step,
	input  wire logic                      level_next,
	input  wire logic [pdd_pkg::HoldW-1:0] holdoff_reload,
	output pdd_pkg::result_t               result
);
	import pdd_pkg::*;

	phase_t           phase_q;
	phase_t           phase_d;
	logic [HoldW-1:0] hold_q;
	logic [HoldW-1:0] hold_dec;
	logic [HoldW-1:0] hold_d;
	logic             down_q;
	logic             drop;
	logic             save;

	always_comb begin
		hold_dec = (hold_q != '0) ? (hold_q - {{(HoldW-1){1'b0}}, 1'b1}) : hold_q;
		hold_d   = hold_dec;
		phase_d  = phase_q;
		drop     = 1'b0;
		save     = 1'b0;
		unique case (phase_q)
			PH_UP: begin
				if (!level_next) begin
					drop    = 1'b1;
					phase_d = PH_LOST;
					if (hold_dec == '0) begin
						save   = 1'b1;
						hold_d = holdoff_reload;
					end
				end
			end
			PH_LOST: begin
				if (level_next) begin
					phase_d = PH_UP;
				end
			end
			default: begin
				phase_d = level_next ? PH_UP : PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hold_q  <= '0;
			down_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			hold_q  <= hold_d;
			down_q  <= down_q | drop;
		end
	end

	always_comb begin
		result.power_good   = level_next;
		result.drop_event   = drop;
		result.save_request = save;
		result.down_flag    = down_q | drop;
		unique case (phase_d)
			PH_UP:   result.phase = PHASE_CODE_UP;
			PH_LOST: result.phase = PHASE_CODE_LOST;
			default: result.phase = PHASE_CODE_IDLE;
		endcase
	end

	a_save_needs_drop: assert property (@(posedge clk) disable iff (!arst_n)
		save |-> drop)
		else $error("save request without a drop");

	a_drop_sets_down: assert property (@(posedge clk) disable iff (!arst_n)
		(step && drop) |=> down_q)
		else $error("down flag not set after a drop");

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase register lost its one-hot code");

endmodule
`default_nettype wire

// ===== hdl/power_drop_detector_unit.sv =====
// Top level of the power drop detector: input register, debounce and phase
// logic, and the result register. Depends on pdd_pkg, pdd_cfg, pdd_debounce, pdd_phase.
`default_nettype none
// A word accepted into the input register is processed when it moves on
// into the result register, which holds its result for the result port;
// the move waits while the result register is full and out_ready is low.
// Throughput: one word per cycle while out_ready does not hold the result
// register; run counters, holdoff timer and phase machine update per word.
// Reset (arst_n low, asynchronous) loads the configuration defaults, clears
// all counters and flags, sets the phase to idle and empties both registers.
module power_drop_detector_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Sample channel.
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [pdd_pkg::SampleW-1:0]   voltage_sample,
	// Result channel.
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               power_good,
	output logic [1:0]                         phase,
	output logic                               drop_event,
	output logic                               save_request,
	output logic                               down_flag,
	// Configuration write channel.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pdd_pkg::CfgIndexW-1:0] cfg_index,
	input  wire logic [pdd_pkg::CfgDataW-1:0]  cfg_data
);
	import pdd_pkg::*;

	cfg_t               cfg;
	logic               valid_s1;
	logic [SampleW-1:0] sample_s1;
	logic               valid_s2;
	result_t            result_s2;
	result_t            result_d;
	logic               level_next;
	logic               out_free;
	logic               step;

	// Configuration writes are always taken; user must only write while idle.
	assign cfg_ready = 1'b1;

	pdd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The result register is free when empty or when its word leaves now.
	// The sample in the input register is processed (and the state updated)
	// exactly in the cycle it moves into the result register.
	assign out_free = !valid_s2 || out_ready;
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= voltage_sample;
		end
		if (step) begin
			result_s2 <= result_d;
		end
	end

	pdd_debounce u_debounce (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.sample     (sample_s1),
		.threshold  (cfg.threshold),
		.debounce   (cfg.debounce),
		.level_next (level_next)
	);

	pdd_phase u_phase (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.level_next     (level_next),
		.holdoff_reload (cfg.holdoff),
		.result         (result_d)
	);

	assign out_valid    = valid_s2;
	assign power_good   = result_s2.power_good;
	assign phase        = result_s2.phase;
	assign drop_event   = result_s2.drop_event;
	assign save_request = result_s2.save_request;
	assign down_flag    = result_s2.down_flag;

	// A stored sample must not be overwritten before it has been processed.
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(sample_s1)))
		else $error("unprocessed sample was lost");

	// Every processed sample shows up as a result word in the next cycle.
	a_step_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("processed sample produced no result word");

endmodule
`default_nettype wire
